### design/hthq_pkg.sv
// Shared widths, field codes and register indexes of the heightmap height query unit.
package hthq_pkg;

  // Field widths of the input and result words.
  localparam int unsigned POS_W      = 16;
  localparam int unsigned VIDX_W     = 16;
  localparam int unsigned HBYTE_W    = 8;
  localparam int unsigned HEIGHT_W   = 16;

  // Configuration port widths.
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

  // Input word modes.
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // Grid size after reset, before clamping to the store size.
  localparam int unsigned GRID_SIDE_RESET = 256;

endpackage

### design/hthq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface hthq_in_if;
  logic                                valid;
  logic                                ready;
  hthq_pkg::mode_t                     mode;
  logic [hthq_pkg::VIDX_W-1:0]         vertex_index;
  logic [hthq_pkg::HBYTE_W-1:0]        height_byte;
  logic [hthq_pkg::POS_W-1:0]          pos_x;
  logic [hthq_pkg::POS_W-1:0]          pos_z;

  modport source (output valid, output mode, output vertex_index, output height_byte,
                  output pos_x, output pos_z, input ready);
  modport sink   (input valid, input mode, input vertex_index, input height_byte,
                  input pos_x, input pos_z, output ready);
endinterface

interface hthq_out_if;
  logic                                valid;
  logic                                ready;
  logic [hthq_pkg::HEIGHT_W-1:0]       height_q8;
  logic                                outside_grid;

  modport source (output valid, output height_q8, output outside_grid, input ready);
  modport sink   (input valid, input height_q8, input outside_grid, output ready);
endinterface

### design/heightmap_triangle_height_query_unit.sv
// Pipelined heightmap store with triangle-plane height interpolation.
//
//   Channel  Dir  Handshake          Word
//   in_ch    in   valid/ready        mode, vertex_index, height_byte, pos_x, pos_z
//   out_ch   out  valid/ready        height_q8, outside_grid
//   cfg_*    in   write enable only  cfg_index selects grid_columns or grid_rows
//
// One word is accepted per cycle unless the output stalls. A query's result goes through
// the input, address, store, product and output registers; a vertex write gives no result.
// The store is split into even and odd banks by vertex index, each read at two
// addresses per cycle, so the four corners of a cell come out in one access.
// Reset clears the pipeline valid bits and restores the grid size; the store is not cleared.
// Each stage holds its word while the stage after it is full and stalled, so bubbles
// close up and input is taken while a result waits at the output.
module heightmap_triangle_height_query_unit #(
  parameter int unsigned MAX_SIDE  = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hthq_in_if.sink                          in_ch,
  hthq_out_if.source                       out_ch,
  input  logic                             cfg_wr_en,
  input  logic [hthq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hthq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned BANK_W     = ADDR_W - 1;
  localparam int unsigned EVEN_DEPTH = (DEPTH + 1) / 2;
  localparam int unsigned ODD_DEPTH  = DEPTH / 2;
  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int unsigned IX_W       = hthq_pkg::POS_W - FRAC_BITS;
  localparam int unsigned W_W        = FRAC_BITS + 1;
  localparam int unsigned DIFF_W     = hthq_pkg::HBYTE_W + 1;
  localparam int unsigned PROD_W     = W_W + 1 + DIFF_W;
  localparam int unsigned ACC_W      = FRAC_BITS + 14;
  localparam int unsigned ONE        = 1 << FRAC_BITS;
  localparam int unsigned SIDE_RESET =
    (hthq_pkg::GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : hthq_pkg::GRID_SIDE_RESET;

  // ---------------------------------------------------------------------------
  // Grid size registers, stored already clamped to the legal range.
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] cols_r, rows_r;
  logic [SIDE_W-1:0] cfg_side;

  always_comb begin
    if (32'(cfg_data) < 32'd2) begin
      cfg_side = SIDE_W'(2);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      cfg_side = SIDE_W'(MAX_SIDE);
    end else begin
      cfg_side = SIDE_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIDE_W'(SIDE_RESET);
      rows_r <= SIDE_W'(SIDE_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hthq_pkg::REG_GRID_COLUMNS: cols_r <= cfg_side;
        hthq_pkg::REG_GRID_ROWS:    rows_r <= cfg_side;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage load enables: a stage loads when it is empty or its word moves on.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ld1, ld2, ld3, ld4, ld5;
  hthq_pkg::mode_t s2_mode_r;

  assign ld5 = !v5_r || out_ch.ready;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_ch.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_ch.valid;
      if (ld2) v2_r <= v1_r;
      // Writes end at the store; only queries go past it.
      if (ld3) v3_r <= v2_r && (s2_mode_r == hthq_pkg::MODE_QUERY);
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input word register.
  // ---------------------------------------------------------------------------
  hthq_pkg::mode_t               s1_mode_r;
  logic [hthq_pkg::VIDX_W-1:0]   s1_vidx_r;
  logic [hthq_pkg::HBYTE_W-1:0]  s1_hbyte_r;
  logic [hthq_pkg::POS_W-1:0]    s1_pos_x_r, s1_pos_z_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_mode_r  <= in_ch.mode;
      s1_vidx_r  <= in_ch.vertex_index;
      s1_hbyte_r <= in_ch.height_byte;
      s1_pos_x_r <= in_ch.pos_x;
      s1_pos_z_r <= in_ch.pos_z;
    end
  end

  // Cell selection, range check and linear addresses of the two cell rows.
  logic [IX_W-1:0]       ix_full, iz_full;
  logic [SIDE_W-1:0]     ix_s, iz_s;
  logic [2*SIDE_W-1:0]   row_off;
  logic [ADDR_W-1:0]     base_idx_nxt, upper_idx_nxt;
  logic                  outside_nxt;
  logic                  wr_ok_nxt;

  always_comb begin
    ix_full       = s1_pos_x_r[hthq_pkg::POS_W-1:FRAC_BITS];
    iz_full       = s1_pos_z_r[hthq_pkg::POS_W-1:FRAC_BITS];
    outside_nxt   = (32'(ix_full) + 32'd1 >= 32'(cols_r)) ||
                    (32'(iz_full) + 32'd1 >= 32'(rows_r));
    ix_s          = SIDE_W'(ix_full);
    iz_s          = SIDE_W'(iz_full);
    row_off       = iz_s * cols_r;
    base_idx_nxt  = ADDR_W'(row_off) + ADDR_W'(ix_s);
    upper_idx_nxt = base_idx_nxt + ADDR_W'(cols_r);
    wr_ok_nxt     = 32'(s1_vidx_r) < DEPTH;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: addresses, fractions and the pending vertex write.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]             s2_wr_idx_r;
  logic                          s2_wr_ok_r;
  logic [hthq_pkg::HBYTE_W-1:0]  s2_hbyte_r;
  logic [ADDR_W-1:0]             s2_base_r, s2_upper_r;
  logic [FRAC_BITS-1:0]          s2_fx_r, s2_fz_r;
  logic                          s2_outside_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_mode_r    <= s1_mode_r;
      s2_wr_idx_r  <= ADDR_W'(s1_vidx_r);
      s2_wr_ok_r   <= wr_ok_nxt;
      s2_hbyte_r   <= s1_hbyte_r;
      s2_base_r    <= base_idx_nxt;
      s2_upper_r   <= upper_idx_nxt;
      s2_fx_r      <= s1_pos_x_r[FRAC_BITS-1:0];
      s2_fz_r      <= s1_pos_z_r[FRAC_BITS-1:0];
      s2_outside_r <= outside_nxt;
    end
  end

  // Bank addresses: entry a lives in bank a[0] at a >> 1. For a pair a, a+1 the even
  // entry sits at (a+1) >> 1 and the odd entry at a >> 1.
  logic [ADDR_W-1:0] base_p1, upper_p1;
  logic [BANK_W-1:0] even_lo_addr, odd_lo_addr, even_hi_addr, odd_hi_addr;
  logic              wr_even, wr_odd;
  logic [BANK_W-1:0] wr_addr;

  always_comb begin
    base_p1      = s2_base_r + ADDR_W'(1);
    upper_p1     = s2_upper_r + ADDR_W'(1);
    even_lo_addr = base_p1[ADDR_W-1:1];
    odd_lo_addr  = s2_base_r[ADDR_W-1:1];
    even_hi_addr = upper_p1[ADDR_W-1:1];
    odd_hi_addr  = s2_upper_r[ADDR_W-1:1];
    wr_addr      = s2_wr_idx_r[ADDR_W-1:1];
    wr_even      = ld3 && v2_r && (s2_mode_r == hthq_pkg::MODE_WRITE) && s2_wr_ok_r &&
                   !s2_wr_idx_r[0];
    wr_odd       = ld3 && v2_r && (s2_mode_r == hthq_pkg::MODE_WRITE) && s2_wr_ok_r &&
                   s2_wr_idx_r[0];
  end

  // ---------------------------------------------------------------------------
  // Height store: even and odd banks, one write and two reads each per cycle.
  // ---------------------------------------------------------------------------
  logic [hthq_pkg::HBYTE_W-1:0] mem_even [EVEN_DEPTH];
  logic [hthq_pkg::HBYTE_W-1:0] mem_odd  [ODD_DEPTH];
  logic [hthq_pkg::HBYTE_W-1:0] even_lo_r, odd_lo_r, even_hi_r, odd_hi_r;

  always_ff @(posedge clk) begin
    if (wr_even) begin
      mem_even[wr_addr] <= s2_hbyte_r;
    end
    if (ld3) begin
      even_lo_r <= mem_even[even_lo_addr];
      even_hi_r <= mem_even[even_hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_odd) begin
      mem_odd[wr_addr] <= s2_hbyte_r;
    end
    if (ld3) begin
      odd_lo_r <= mem_odd[odd_lo_addr];
      odd_hi_r <= mem_odd[odd_hi_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: corner heights arrive; pick the triangle and form both weighted terms.
  // ---------------------------------------------------------------------------
  logic                 s3_lo_par_r, s3_hi_par_r;
  logic [FRAC_BITS-1:0] s3_fx_r, s3_fz_r;
  logic                 s3_outside_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_lo_par_r  <= s2_base_r[0];
      s3_hi_par_r  <= s2_upper_r[0];
      s3_fx_r      <= s2_fx_r;
      s3_fz_r      <= s2_fz_r;
      s3_outside_r <= s2_outside_r;
    end
  end

  logic [hthq_pkg::HBYTE_W-1:0] h0, h1, h2, h3, base_h_nxt;
  logic                         upper_tri;
  logic [W_W-1:0]               wa, wb;
  logic signed [DIFF_W-1:0]     da, db;
  logic signed [PROD_W-1:0]     prod_a_nxt, prod_b_nxt;

  always_comb begin
    // Lower row: h3 at x low, h2 at x high. Upper row: h0 at x low, h1 at x high.
    h3 = s3_lo_par_r ? odd_lo_r  : even_lo_r;
    h2 = s3_lo_par_r ? even_lo_r : odd_lo_r;
    h0 = s3_hi_par_r ? odd_hi_r  : even_hi_r;
    h1 = s3_hi_par_r ? even_hi_r : odd_hi_r;
    upper_tri = (W_W'(s3_fx_r) + W_W'(s3_fz_r)) >= W_W'(ONE);
    if (upper_tri) begin
      base_h_nxt = h1;
      wa = W_W'(ONE) - W_W'(s3_fx_r);
      wb = W_W'(ONE) - W_W'(s3_fz_r);
      da = $signed({1'b0, h0}) - $signed({1'b0, h1});
      db = $signed({1'b0, h2}) - $signed({1'b0, h1});
    end else begin
      base_h_nxt = h3;
      wa = W_W'(s3_fx_r);
      wb = W_W'(s3_fz_r);
      da = $signed({1'b0, h2}) - $signed({1'b0, h3});
      db = $signed({1'b0, h0}) - $signed({1'b0, h3});
    end
    prod_a_nxt = $signed({1'b0, wa}) * da;
    prod_b_nxt = $signed({1'b0, wb}) * db;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: products registered; sum, clamp and saturate.
  // ---------------------------------------------------------------------------
  logic [hthq_pkg::HBYTE_W-1:0] s4_base_h_r;
  logic signed [PROD_W-1:0]     s4_prod_a_r, s4_prod_b_r;
  logic                         s4_outside_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_base_h_r  <= base_h_nxt;
      s4_prod_a_r  <= prod_a_nxt;
      s4_prod_b_r  <= prod_b_nxt;
      s4_outside_r <= s3_outside_r;
    end
  end

  logic signed [ACC_W-1:0]       acc;
  logic [hthq_pkg::HEIGHT_W-1:0] height_nxt;

  always_comb begin
    acc = $signed(ACC_W'({s4_base_h_r, {FRAC_BITS{1'b0}}})) +
          ACC_W'(s4_prod_a_r) + ACC_W'(s4_prod_b_r);
    if (s4_outside_r || acc[ACC_W-1]) begin
      height_nxt = '0;
    end else if (acc[ACC_W-2:hthq_pkg::HEIGHT_W] != '0) begin
      height_nxt = '1;
    end else begin
      height_nxt = acc[hthq_pkg::HEIGHT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: output register.
  // ---------------------------------------------------------------------------
  logic [hthq_pkg::HEIGHT_W-1:0] out_height_r;
  logic                          out_outside_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_height_r  <= height_nxt;
      out_outside_r <= s4_outside_r;
    end
  end

  assign out_ch.valid        = v5_r;
  assign out_ch.height_q8    = out_height_r;
  assign out_ch.outside_grid = out_outside_r;

endmodule

### design/hthq_checker.sv
// Port-level checks of the heightmap height query unit, bound to its top level.
module hthq_checker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hthq_pkg::HEIGHT_W-1:0]  out_height_q8,
  input logic                           out_outside_grid
);

  localparam int unsigned HEIGHT_LIMIT = 255 << FRAC_BITS;

  // A result word that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height_q8) &&
                                $stable(out_outside_grid))
    else $error("result word changed while stalled");

  // A cell outside the grid always reports height zero.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside_grid |-> out_height_q8 == '0)
    else $error("outside-grid result with nonzero height");

  // An interpolated height never exceeds the largest height a vertex byte can hold.
  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_height_q8) <= HEIGHT_LIMIT)
    else $error("height above the largest vertex height");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind heightmap_triangle_height_query_unit hthq_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_hthq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_height_q8    (out_ch.height_q8),
  .out_outside_grid (out_ch.outside_grid)
);

### tb/tb_top.sv
// Self-checking testbench of the heightmap triangle height query unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_SIDE          = 256;
  localparam int unsigned FRAC_BITS         = 8;
  localparam int          ONE               = 1 << FRAC_BITS;
  localparam int unsigned STORE_DEPTH       = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ITEMS_PER_PHASE   = 92;
  localparam int unsigned PHASES            = 9;
  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned END_CYCLES        = 10;
  localparam int unsigned LONG_STALL_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned DIRECTED_ROWS     = 23;

  // One result word as the block returns it.
  typedef struct packed {
    logic [hthq_pkg::HEIGHT_W-1:0] height;
    logic                          outside;
  } height_result_t;

  // One row of the directed stimulus, with an optional hand-typed expectation.
  typedef struct packed {
    hthq_pkg::mode_t               mode;
    logic [hthq_pkg::VIDX_W-1:0]   vertex_index;
    logic [hthq_pkg::HBYTE_W-1:0]  height_byte;
    logic [hthq_pkg::POS_W-1:0]    pos_x;
    logic [hthq_pkg::POS_W-1:0]    pos_z;
    bit                            typed;
    logic [hthq_pkg::HEIGHT_W-1:0] typed_height;
    logic                          typed_outside;
  } query_row_t;

  logic clk;
  logic rst_n;
  logic                            cfg_wr_en;
  logic [hthq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hthq_pkg::CFG_DATA_W-1:0] cfg_data;

  hthq_in_if  in_ch();
  hthq_out_if out_ch();

  heightmap_triangle_height_query_unit #(
    .MAX_SIDE (MAX_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the block's state: vertex heights, which ones were written, grid size.
  logic [hthq_pkg::HBYTE_W-1:0]    vertex_heights [STORE_DEPTH];
  bit                              vertex_written [STORE_DEPTH];
  logic [hthq_pkg::CFG_DATA_W-1:0] grid_cols_raw;
  logic [hthq_pkg::CFG_DATA_W-1:0] grid_rows_raw;

  height_result_t pending_heights [$];
  int unsigned    mismatches      = 0;
  int unsigned    send_idle_pct   = 28;
  int unsigned    recv_idle_pct   = 77;
  bit             want_long_stall = 1'b0;

  // Directed words: corners of the first and last cells, both triangles, the
  // diagonal boundary, cells outside the grid and a query right after a write.
  query_row_t directed_rows [DIRECTED_ROWS] = '{
    '{hthq_pkg::MODE_WRITE, 16'd0,     8'd0,   16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd1,     8'd255, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd256,   8'd255, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd257,   8'd0,   16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0000, 16'h0000, 1'b1, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0080, 16'h0080, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h00FF, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0000, 16'h00FF, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0080, 16'h007F, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h00FF, 16'h00FF, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'hFF00, 16'h0000, 1'b1, 16'd0,     1'b1},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0000, 16'hFF00, 1'b1, 16'd0,     1'b1},
    '{hthq_pkg::MODE_QUERY, 16'hFFFF,  8'hFF,  16'hFFFF, 16'hFFFF, 1'b1, 16'd0,     1'b1},
    '{hthq_pkg::MODE_WRITE, 16'd65278, 8'd255, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd65279, 8'd255, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd65534, 8'd255, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd65535, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'hFEFF, 16'hFEFF, 1'b1, 16'd65280, 1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'hFE00, 16'hFE00, 1'b1, 16'd65280, 1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd0,     8'd200, 16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h0000, 16'h0000, 1'b1, 16'd51200, 1'b0},
    '{hthq_pkg::MODE_WRITE, 16'd1,     8'h5A,  16'h0000, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{hthq_pkg::MODE_QUERY, 16'd0,     8'd0,   16'h00FF, 16'h0000, 1'b0, 16'd0,     1'b0}
  };

  // Grid sizes of the random phases, out-of-range values among them.
  logic [hthq_pkg::CFG_DATA_W-1:0] phase_cols [PHASES] =
    '{9'd2, 9'd0, 9'd3, 9'd511, 9'd256, 9'd2, 9'd16, 9'd257, 9'd9};
  logic [hthq_pkg::CFG_DATA_W-1:0] phase_rows [PHASES] =
    '{9'd2, 9'd1, 9'd17, 9'd300, 9'd2, 9'd256, 9'd16, 9'd40, 9'd5};

  // A grid side below two acts as two, one above the store side as the store side.
  function automatic int unsigned effective_side(
      input logic [hthq_pkg::CFG_DATA_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return raw;
  endfunction

  function automatic int stored_height(input int unsigned col, input int unsigned row,
                                       input int unsigned cols);
    int unsigned idx;
    idx = row * cols + col;
    if (idx >= STORE_DEPTH) return 0;
    return int'(vertex_heights[idx]);
  endfunction

  // True when all four corners of the cell have been written.
  function automatic bit cell_written(input int unsigned cx, input int unsigned cz);
    int unsigned cols;
    int unsigned base;
    cols = effective_side(grid_cols_raw);
    base = cz * cols + cx;
    return vertex_written[base] && vertex_written[base + 1] &&
           vertex_written[base + cols] && vertex_written[base + cols + 1];
  endfunction

  // Height on the plane of the triangle that holds the position.
  function automatic height_result_t predict_height(
      input logic [hthq_pkg::POS_W-1:0] px, input logic [hthq_pkg::POS_W-1:0] pz);
    int unsigned    cols, rows, ix, iz;
    int             fx, fz, h0, h1, h2, h3, acc;
    height_result_t res;
    cols = effective_side(grid_cols_raw);
    rows = effective_side(grid_rows_raw);
    ix   = px >> FRAC_BITS;
    iz   = pz >> FRAC_BITS;
    fx   = int'(px) & (ONE - 1);
    fz   = int'(pz) & (ONE - 1);
    if (ix >= cols - 1 || iz >= rows - 1) begin
      res.height  = '0;
      res.outside = 1'b1;
      return res;
    end
    h0 = stored_height(ix, iz + 1, cols);
    h1 = stored_height(ix + 1, iz + 1, cols);
    h2 = stored_height(ix + 1, iz, cols);
    h3 = stored_height(ix, iz, cols);
    if (fx + fz >= ONE) begin
      acc = h1 * ONE + (ONE - fx) * (h0 - h1) + (ONE - fz) * (h2 - h1);
    end else begin
      acc = h3 * ONE + fx * (h2 - h3) + fz * (h0 - h3);
    end
    if (acc < 0) acc = 0;
    if (acc > 16'hFFFF) acc = 16'hFFFF;
    res.height  = acc[hthq_pkg::HEIGHT_W-1:0];
    res.outside = 1'b0;
    return res;
  endfunction

  // Offer one word, starting at a falling edge; the mirror and the expected
  // heights are updated at the rising edge that accepts it.
  task automatic send_item(input hthq_pkg::mode_t m,
                           input logic [hthq_pkg::VIDX_W-1:0] vidx,
                           input logic [hthq_pkg::HBYTE_W-1:0] hb,
                           input logic [hthq_pkg::POS_W-1:0] px,
                           input logic [hthq_pkg::POS_W-1:0] pz, input bit typed,
                           input height_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.vertex_index <= vidx;
    in_ch.height_byte  <= hb;
    in_ch.pos_x        <= px;
    in_ch.pos_z        <= pz;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (m == hthq_pkg::MODE_WRITE) begin
      vertex_heights[vidx] = hb;
      vertex_written[vidx] = 1'b1;
    end else begin
      pending_heights.push_back(typed ? typed_res : predict_height(px, pz));
    end
    @(negedge clk);
  endtask

  // Stop offering words until every expected height has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_heights.size() != 0);
  endtask

  // Both grid registers, written on back-to-back cycles while the block is idle.
  task automatic program_grid(input logic [hthq_pkg::CFG_DATA_W-1:0] cols,
                              input logic [hthq_pkg::CFG_DATA_W-1:0] rows);
    cfg_wr_en <= 1'b1;
    cfg_index <= hthq_pkg::REG_GRID_COLUMNS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= hthq_pkg::REG_GRID_ROWS;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    grid_cols_raw = cols;
    grid_rows_raw = rows;
  endtask

  // Write the corners of a random cell if not all written (else only at random), then
  // query points inside it, often right on the diagonal between its two triangles.
  task automatic cell_burst(output int unsigned count);
    int unsigned                  cols, rows, cx, cz, base, idx, fx, fz, pick;
    logic [hthq_pkg::HBYTE_W-1:0] hb;
    cols  = effective_side(grid_cols_raw);
    rows  = effective_side(grid_rows_raw);
    cx    = $urandom_range(0, cols - 2);
    cz    = $urandom_range(0, rows - 2);
    base  = cz * cols + cx;
    count = 0;
    if (!cell_written(cx, cz) || $urandom_range(1) == 1) begin
      for (int k = 0; k < 4; k++) begin
        idx = base + (k % 2) + (k / 2) * cols;
        if ($urandom_range(4) == 0) begin
          hb = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          hb = 8'($urandom_range(255));
        end
        send_item(hthq_pkg::MODE_WRITE, 16'(idx), hb, 16'($urandom), 16'($urandom),
                  1'b0, '0);
        count++;
      end
    end
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(9);
      fx   = $urandom_range(255);
      if (pick < 2) begin
        fx = $urandom_range(1, 255);
        fz = 256 - fx;
      end else if (pick < 4) begin
        fz = 255 - fx;
      end else begin
        fz = $urandom_range(255);
      end
      send_item(hthq_pkg::MODE_QUERY, 16'($urandom), 8'($urandom),
                16'((cx << FRAC_BITS) | fx), 16'((cz << FRAC_BITS) | fz), 1'b0, '0);
      count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, and one long hold-off on request so the block fills up.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_long_stall) begin
        want_long_stall = 1'b0;
        stall_left      = LONG_STALL_CYCLES;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest expected height.
  always @(posedge clk) begin : check_results
    height_result_t got, want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.height  = out_ch.height_q8;
      got.outside = out_ch.outside_grid;
      if (pending_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: height %0d outside %0b", got.height,
                   got.outside);
        end
      end else begin
        want = pending_heights.pop_front();
        if (got.height !== want.height || got.outside !== want.outside) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected height %0d outside %0b, got %0d %0b",
                     want.height, want.outside, got.height, got.outside);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", quiet);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Main stimulus: directed words, then random phases over several grid sizes.
  initial begin
    int unsigned                  sent, n, choice, cols, rows, cx, cz;
    bit                           stall_asked, pause_done;
    logic [hthq_pkg::POS_W-1:0]   px, pz;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = hthq_pkg::MODE_WRITE;
    in_ch.vertex_index = '0;
    in_ch.height_byte  = '0;
    in_ch.pos_x        = '0;
    in_ch.pos_z        = '0;
    cfg_wr_en          = 1'b0;
    cfg_index          = hthq_pkg::REG_GRID_COLUMNS;
    cfg_data           = '0;
    grid_cols_raw      = hthq_pkg::CFG_DATA_W'(hthq_pkg::GRID_SIDE_RESET);
    grid_rows_raw      = hthq_pkg::CFG_DATA_W'(hthq_pkg::GRID_SIDE_RESET);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].mode, directed_rows[i].vertex_index,
                directed_rows[i].height_byte, directed_rows[i].pos_x,
                directed_rows[i].pos_z, directed_rows[i].typed,
                '{height: directed_rows[i].typed_height,
                  outside: directed_rows[i].typed_outside});
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 28;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // The grid size changes only once the pipeline has drained, writes included.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      program_grid(phase_cols[p], phase_rows[p]);
      cols        = effective_side(grid_cols_raw);
      rows        = effective_side(grid_rows_raw);
      sent        = 0;
      stall_asked = 1'b0;
      pause_done  = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (!stall_asked && sent >= ITEMS_PER_PHASE / 3) begin
          want_long_stall = 1'b1;
          stall_asked     = 1'b1;
        end
        if (!pause_done && sent >= 2 * ITEMS_PER_PHASE / 3) begin
          wait_for_results();
          pause_done = 1'b1;
        end
        choice = $urandom_range(99);
        n      = 1;
        if (choice < 55) begin
          cell_burst(n);
        end else if (choice < 70) begin
          // Stray write anywhere in the store.
          send_item(hthq_pkg::MODE_WRITE, 16'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom), 1'b0, '0);
        end else if (choice < 85) begin
          // Query with at least one cell coordinate past the last row or column.
          px = 16'($urandom);
          pz = 16'($urandom);
          if ($urandom_range(1) == 1) begin
            px[hthq_pkg::POS_W-1:FRAC_BITS] = 8'($urandom_range(cols - 1, 255));
          end else begin
            pz[hthq_pkg::POS_W-1:FRAC_BITS] = 8'($urandom_range(rows - 1, 255));
          end
          send_item(hthq_pkg::MODE_QUERY, 16'($urandom), 8'($urandom), px, pz, 1'b0, '0);
        end else begin
          // Revisit a random cell; one not fully written is pushed outside the grid.
          cx = $urandom_range(0, cols - 2);
          cz = $urandom_range(0, rows - 2);
          px = 16'((cx << FRAC_BITS) | $urandom_range(255));
          pz = 16'((cz << FRAC_BITS) | $urandom_range(255));
          if (!cell_written(cx, cz)) begin
            pz[hthq_pkg::POS_W-1:FRAC_BITS] = 8'($urandom_range(rows - 1, 255));
          end
          send_item(hthq_pkg::MODE_QUERY, 16'($urandom), 8'($urandom), px, pz, 1'b0, '0);
        end
        sent += n;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_heights.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
